>>> rtl/core/frame_message_validator_top_macros.svh
// ----------------------------------------------------------------------------
// frame_message_validator_top_macros.svh
// Assertion macros shared by the frame message validator.
// ----------------------------------------------------------------------------
`ifndef FRAME_MESSAGE_VALIDATOR_TOP_MACROS_SVH
`define FRAME_MESSAGE_VALIDATOR_TOP_MACROS_SVH

// same-cycle implication
`define FMV_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FMV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/fmv_pkg.sv
// ----------------------------------------------------------------------------
// fmv_pkg
// Types and codes shared by the frame message validator modules.
// ----------------------------------------------------------------------------
package fmv_pkg;

	localparam logic [12:0] MAX_SIDE = 13'd4096;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam logic [2:0] OP_BEGIN  = 3'd0;
	localparam logic [2:0] OP_RECT   = 3'd1;
	localparam logic [2:0] OP_END    = 3'd2;
	localparam logic [2:0] OP_OTHER  = 3'd3;
	localparam logic [2:0] OP_STREAM = 3'd4;
	localparam logic [2:0] OP_RESET  = 3'd5;

	localparam logic [1:0] EV_BEGIN   = 2'd0;
	localparam logic [1:0] EV_RECT    = 2'd1;
	localparam logic [1:0] EV_COMMIT  = 2'd2;
	localparam logic [1:0] EV_DISCARD = 2'd3;

	localparam logic [3:0] R_ABORTED    = 4'd0;
	localparam logic [3:0] R_LAYOUT     = 4'd1;
	localparam logic [3:0] R_ID         = 4'd2;
	localparam logic [3:0] R_RECTS      = 4'd3;
	localparam logic [3:0] R_BYTES      = 4'd4;
	localparam logic [3:0] R_BEGIN      = 4'd5;
	localparam logic [3:0] R_RECT       = 4'd6;
	localparam logic [3:0] R_STREAM     = 4'd7;
	localparam logic [3:0] R_PARTIAL    = 4'd8;
	localparam logic [3:0] R_SUPERSEDED = 4'd9;
	localparam logic [3:0] R_RESET      = 4'd10;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_IN   = 2'd1;
	localparam logic [1:0] MODE_DISC = 2'd2;

	localparam logic [2:0] CFG_MAX_PAYLOAD  = 3'd0;
	localparam logic [2:0] CFG_MAX_RECTS    = 3'd1;
	localparam logic [2:0] CFG_FULL_CODE    = 3'd2;
	localparam logic [2:0] CFG_PARTIAL_CODE = 3'd3;
	localparam logic [2:0] CFG_RGB565_CODE  = 3'd4;
	localparam logic [2:0] CFG_ABORT_MASK   = 3'd5;

	typedef struct packed {
		logic [25:0] max_payload;
		logic [15:0] max_rects;
		logic [7:0]  full_code;
		logic [7:0]  partial_code;
		logic [7:0]  rgb565_code;
		logic [7:0]  abort_mask;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		max_payload:  26'd33554440,
		max_rects:    16'd65535,
		full_code:    8'd0,
		partial_code: 8'd1,
		rgb565_code:  8'd0,
		abort_mask:   8'd1
	};

	typedef struct packed {
		logic [2:0]  op;
		logic [25:0] len;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] tl;
	} item_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] id;
		logic        partial;
		logic [7:0]  fmt;
		logic [12:0] width;
		logic [12:0] height;
		logic [31:0] hint;
		logic [15:0] rects;
		logic [31:0] bytes;
		logic        base;
	} st_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [3:0]  reason;
		logic [15:0] frame_id;
		logic        frame_kind;
		logic [7:0]  pixel_format;
		logic [12:0] size_w;
		logic [12:0] size_h;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [15:0] rect_total;
		logic [31:0] byte_total;
		logic        last;
	} res_t;

endpackage

>>> rtl/core/fmv_check.sv
// ----------------------------------------------------------------------------
// fmv_check
// Evaluates one message header against the frame state; gives next state and
// up to two result items.
// ----------------------------------------------------------------------------
module fmv_check import fmv_pkg::*; (
	input  st_t        st,
	input  cfg_t       cfg,
	input  item_t      it,
	output st_t        st_n,
	output res_t       res0,
	output res_t       res1,
	output logic [1:0] nres
);

	function automatic res_t mk_discard(input logic [3:0] why);
		res_t r;
		r           = '0;
		r.event_res = EV_DISCARD;
		r.reason    = why;
		return r;
	endfunction

	logic [7:0]  b_type, b_fmt;
	logic [15:0] b_w, b_h;
	logic        b_ok;
	res_t        b_res;

	logic [15:0] r_x, r_y, r_w, r_h;
	logic [16:0] r_xw, r_yh;
	logic        r_ok1, r_ok;
	logic [25:0] r_prod, r_pb;
	logic [32:0] r_sum;

	logic [7:0]  e_flags;
	logic        e_fail;
	logic [3:0]  e_reason;

	assign b_type = it.lo[23:16];
	assign b_fmt  = it.lo[31:24];
	assign b_w    = it.hi[15:0];
	assign b_h    = it.hi[31:16];
	assign b_ok   = (it.len == 26'd12)
		&& ((b_type == cfg.full_code) || (b_type == cfg.partial_code))
		&& (b_fmt == cfg.rgb565_code)
		&& (b_w != 16'd0) && (b_w <= 16'(MAX_SIDE))
		&& (b_h != 16'd0) && (b_h <= 16'(MAX_SIDE));

	always_comb begin
		b_res              = '0;
		b_res.event_res    = EV_BEGIN;
		b_res.frame_id     = it.lo[15:0];
		b_res.frame_kind   = (b_type == cfg.partial_code);
		b_res.pixel_format = b_fmt;
		b_res.size_w       = b_w[12:0];
		b_res.size_h       = b_h[12:0];
		b_res.byte_total   = it.tl;
	end

	assign r_x    = it.lo[15:0];
	assign r_y    = it.lo[31:16];
	assign r_w    = it.hi[15:0];
	assign r_h    = it.hi[31:16];
	assign r_xw   = {1'b0, r_x} + {1'b0, r_w};
	assign r_yh   = {1'b0, r_y} + {1'b0, r_h};
	assign r_ok1  = (it.len >= 26'd8) && (it.len <= cfg.max_payload)
		&& (r_w != 16'd0) && (r_h != 16'd0)
		&& (st.fmt == cfg.rgb565_code)
		&& (r_xw <= 17'(st.width)) && (r_yh <= 17'(st.height));
	// side lengths fit 13 bits whenever the geometry checks pass
	assign r_prod = 26'(r_w[12:0]) * 26'(r_h[12:0]);
	assign r_pb   = {r_prod[24:0], 1'b0};
	assign r_sum  = {1'b0, st.bytes} + {7'd0, r_pb};
	assign r_ok   = r_ok1 && (it.len == (26'd8 + r_pb))
		&& (st.rects < cfg.max_rects) && !r_sum[32];

	assign e_flags = it.tl[7:0];

	always_comb begin
		e_fail   = 1'b1;
		e_reason = R_LAYOUT;
		if (it.len != 26'd9) begin
			e_reason = R_LAYOUT;
		end else if ((e_flags & cfg.abort_mask) != 8'd0) begin
			e_reason = R_ABORTED;
		end else if ((e_flags & ~cfg.abort_mask) != 8'd0) begin
			e_reason = R_LAYOUT;
		end else if (it.lo[15:0] != st.id) begin
			e_reason = R_ID;
		end else if (it.lo[31:16] != st.rects) begin
			e_reason = R_RECTS;
		end else if (it.hi != st.bytes) begin
			e_reason = R_BYTES;
		end else if (st.partial && !st.base) begin
			e_reason = R_PARTIAL;
		end else begin
			e_fail = 1'b0;
		end
	end

	always_comb begin
		st_n = st;
		res0 = '0;
		res1 = '0;
		nres = 2'd0;
		case (it.op)
			OP_BEGIN: begin
				if (!b_ok) begin
					if (st.mode != MODE_DISC) begin
						res0      = mk_discard(R_BEGIN);
						nres      = 2'd1;
						st_n.mode = MODE_DISC;
					end
				end else begin
					st_n.mode    = MODE_IN;
					st_n.id      = it.lo[15:0];
					st_n.partial = (b_type == cfg.partial_code);
					st_n.fmt     = b_fmt;
					st_n.width   = b_w[12:0];
					st_n.height  = b_h[12:0];
					st_n.hint    = it.tl;
					st_n.rects   = 16'd0;
					st_n.bytes   = 32'd0;
					if (st.mode == MODE_IN) begin
						res0 = mk_discard(R_SUPERSEDED);
						res1 = b_res;
						nres = 2'd2;
					end else begin
						res0 = b_res;
						nres = 2'd1;
					end
				end
			end
			OP_RECT: begin
				if (st.mode == MODE_IN) begin
					nres = 2'd1;
					if (!r_ok) begin
						res0      = mk_discard(R_RECT);
						st_n.mode = MODE_DISC;
					end else begin
						st_n.rects      = st.rects + 16'd1;
						st_n.bytes      = r_sum[31:0];
						res0.event_res  = EV_RECT;
						res0.size_w     = r_w[12:0];
						res0.size_h     = r_h[12:0];
						res0.pos_x      = r_x[11:0];
						res0.pos_y      = r_y[11:0];
						res0.byte_total = {6'd0, r_pb};
					end
				end
			end
			OP_END: begin
				if (st.mode == MODE_IN) begin
					nres = 2'd1;
					if (e_fail) begin
						res0      = mk_discard(e_reason);
						st_n.mode = MODE_DISC;
					end else begin
						res0.event_res    = EV_COMMIT;
						res0.frame_id     = st.id;
						res0.frame_kind   = st.partial;
						res0.pixel_format = st.fmt;
						res0.size_w       = st.width;
						res0.size_h       = st.height;
						res0.rect_total   = st.rects;
						res0.byte_total   = st.bytes;
						st_n              = '0;
						st_n.base         = 1'b1;
					end
				end
			end
			OP_STREAM: begin
				if (st.mode == MODE_IN) begin
					res0      = mk_discard(R_STREAM);
					nres      = 2'd1;
					st_n.mode = MODE_DISC;
				end
			end
			OP_RESET: begin
				if (st.mode == MODE_IN) begin
					res0 = mk_discard(R_RESET);
					nres = 2'd1;
				end
				st_n = '0;
			end
			default: begin
			end
		endcase
		if (nres == 2'd1) begin
			res0.last = 1'b1;
		end
		if (nres == 2'd2) begin
			res1.last = 1'b1;
		end
	end

endmodule

>>> rtl/core/fmv_resq.sv
// ----------------------------------------------------------------------------
// fmv_resq
// Small result queue; takes up to two items a cycle, gives one.
// ----------------------------------------------------------------------------
module fmv_resq import fmv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  res_t       d0,
	input  res_t       d1,
	input  logic       pop,
	output logic       room,
	output logic       valid,
	output res_t       head
);

	res_t              ent_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_q, rd_q, wr_p1;
	logic [Q_AW:0]     cnt_q;

	assign wr_p1 = wr_q + Q_AW'(1);
	assign room  = (cnt_q <= (Q_AW+1)'(Q_DEPTH - 2));
	assign valid = (cnt_q != '0);
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			ent_q[wr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			ent_q[wr_p1] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + Q_AW'(push_n);
			rd_q  <= rd_q + Q_AW'(pop);
			cnt_q <= cnt_q + (Q_AW+1)'(push_n) - (Q_AW+1)'(pop);
		end
	end

endmodule

>>> rtl/core/frame_message_validator_top.sv
// ----------------------------------------------------------------------------
// frame_message_validator_top
// Checks frame protocol message headers and reports frame-level events.
// ----------------------------------------------------------------------------
// One message header is taken per cycle into an input register, checked in
// the following cycle against the frame state, and its results (none, one,
// or two for a begin that supersedes an open frame) are written to a
// four-entry result queue, from whose head the first result reaches the
// output. The output side gives one result per cycle while out_stall is low,
// so headers flow at one per cycle while each causes at most one result and
// the output is not stalled. Input stalls while the input register holds a
// header and the queue has fewer than two free entries.
// ----------------------------------------------------------------------------
`include "frame_message_validator_top_macros.svh"

module frame_message_validator_top import fmv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [25:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [25:0] payload_len,
	input  logic [31:0] head_low,
	input  logic [31:0] head_high,
	input  logic [31:0] head_tail,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_res,
	output logic [3:0]  reason,
	output logic [15:0] frame_id,
	output logic        frame_kind,
	output logic [7:0]  pixel_format,
	output logic [12:0] size_w,
	output logic [12:0] size_h,
	output logic [11:0] pos_x,
	output logic [11:0] pos_y,
	output logic [15:0] rect_total,
	output logic [31:0] byte_total,
	output logic        last
);

	cfg_t       cfg_q;
	st_t        st_q, st_n;
	item_t      it_s1;
	logic       valid_s1;
	logic       room, adv, pop;
	res_t       res0, res1, head;
	logic [1:0] nres, push_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MAX_PAYLOAD:  cfg_q.max_payload  <= cfg_data;
				CFG_MAX_RECTS:    cfg_q.max_rects    <= cfg_data[15:0];
				CFG_FULL_CODE:    cfg_q.full_code    <= cfg_data[7:0];
				CFG_PARTIAL_CODE: cfg_q.partial_code <= cfg_data[7:0];
				CFG_RGB565_CODE:  cfg_q.rgb565_code  <= cfg_data[7:0];
				CFG_ABORT_MASK:   cfg_q.abort_mask   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign adv      = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			it_s1 <= '{op: opcode, len: payload_len, lo: head_low, hi: head_high,
				tl: head_tail};
		end
	end

	fmv_check u_check (
		.st   (st_q),
		.cfg  (cfg_q),
		.it   (it_s1),
		.st_n (st_n),
		.res0 (res0),
		.res1 (res1),
		.nres (nres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_n;
		end
	end

	assign push_n = adv ? nres : 2'd0;
	assign pop    = out_valid && !out_stall;

	fmv_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.d0     (res0),
		.d1     (res1),
		.pop    (pop),
		.room   (room),
		.valid  (out_valid),
		.head   (head)
	);

	assign event_res    = head.event_res;
	assign reason       = head.reason;
	assign frame_id     = head.frame_id;
	assign frame_kind   = head.frame_kind;
	assign pixel_format = head.pixel_format;
	assign size_w       = head.size_w;
	assign size_h       = head.size_h;
	assign pos_x        = head.pos_x;
	assign pos_y        = head.pos_y;
	assign rect_total   = head.rect_total;
	assign byte_total   = head.byte_total;
	assign last         = head.last;

	`FMV_ASSERT_SAME(a_two_last, adv && (nres == 2'd2), !res0.last && res1.last, "last misplaced")
	`FMV_ASSERT_NEXT(a_commit_idle, adv && (nres != 2'd0) && (res0.event_res == EV_COMMIT), st_q.mode == MODE_IDLE, "no idle after commit")
	`FMV_ASSERT_SAME(a_disc_quiet, adv && (st_q.mode == MODE_DISC) && ((it_s1.op == OP_RECT) || (it_s1.op == OP_END)), nres == 2'd0, "result while discarding")

endmodule

>>> test/fmv_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmv_event_checker
// Watches the frame message validator's ports, predicts its events and
// compares them.
// ----------------------------------------------------------------------------
// Keeps its own copy of the registers and of the frame state. Each item
// taken on the input side is run through the frame rules, and the events it
// causes are queued. Each event taken on the output side is compared with
// the oldest queued one. The mismatch count and the number of events still
// due are handed to the testbench top.
// ----------------------------------------------------------------------------
module fmv_event_checker import fmv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [25:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [25:0] payload_len,
	input  logic [31:0] head_low,
	input  logic [31:0] head_high,
	input  logic [31:0] head_tail,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  event_res,
	input  logic [3:0]  reason,
	input  logic [15:0] frame_id,
	input  logic        frame_kind,
	input  logic [7:0]  pixel_format,
	input  logic [12:0] size_w,
	input  logic [12:0] size_h,
	input  logic [11:0] pos_x,
	input  logic [11:0] pos_y,
	input  logic [15:0] rect_total,
	input  logic [31:0] byte_total,
	input  logic        last,
	output int          mismatches,
	output int          outstanding
);

	cfg_t regs = CFG_RESET;
	st_t  frame = '0;
	res_t events_due[$];
	res_t got;
	res_t want;

	function automatic string show(res_t r);
		return $sformatf({"ev %0d why %0d id %h kind %0d fmt %h w %0d h %0d x %0d y %0d",
			" rects %0d bytes %h last %0d"}, r.event_res, r.reason, r.frame_id,
			r.frame_kind, r.pixel_format, r.size_w, r.size_h, r.pos_x, r.pos_y,
			r.rect_total, r.byte_total, r.last);
	endfunction

	function automatic void drop_frame(logic [3:0] why);
		res_t r;
		r = '0;
		r.event_res = EV_DISCARD;
		r.reason = why;
		events_due.push_back(r);
		frame.mode = MODE_DISC;
	endfunction

	function automatic res_t frame_event(logic [1:0] ev);
		res_t r;
		r = '0;
		r.event_res = ev;
		r.frame_id = frame.id;
		r.frame_kind = frame.partial;
		r.pixel_format = frame.fmt;
		r.size_w = frame.width;
		r.size_h = frame.height;
		return r;
	endfunction

	function automatic void clear_frame();
		logic keep_base;
		keep_base = frame.base;
		frame = '0;
		frame.mode = MODE_IDLE;
		frame.base = keep_base;
	endfunction

	function automatic void predict_events(item_t it);
		logic [7:0]  kind_byte;
		logic [7:0]  fmt_byte;
		logic [15:0] fx;
		logic [15:0] fy;
		logic [15:0] fw;
		logic [15:0] fh;
		logic [63:0] pix_bytes;
		logic        ok;
		res_t        r;
		int          n0;
		n0 = events_due.size();
		kind_byte = it.lo[23:16];
		fmt_byte = it.lo[31:24];
		fx = it.lo[15:0];
		fy = it.lo[31:16];
		fw = it.hi[15:0];
		fh = it.hi[31:16];
		case (it.op)
			OP_BEGIN: begin
				ok = it.len == 26'd12 &&
					(kind_byte == regs.full_code || kind_byte == regs.partial_code) &&
					fmt_byte == regs.rgb565_code && fw >= 16'd1 && fw <= MAX_SIDE &&
					fh >= 16'd1 && fh <= MAX_SIDE;
				if (!ok) begin
					if (frame.mode != MODE_DISC)
						drop_frame(R_BEGIN);
				end else begin
					if (frame.mode == MODE_IN)
						drop_frame(R_SUPERSEDED);
					frame.mode = MODE_IN;
					frame.id = fx;
					frame.partial = kind_byte == regs.partial_code;
					frame.fmt = fmt_byte;
					frame.width = fw[12:0];
					frame.height = fh[12:0];
					frame.hint = it.tl;
					frame.rects = '0;
					frame.bytes = '0;
					r = frame_event(EV_BEGIN);
					r.byte_total = frame.hint;
					events_due.push_back(r);
				end
			end
			OP_RECT: begin
				if (frame.mode == MODE_IN) begin
					ok = it.len >= 26'd8 && it.len <= regs.max_payload &&
						fw >= 16'd1 && fh >= 16'd1 && frame.fmt == regs.rgb565_code &&
						({1'b0, fx} + {1'b0, fw}) <= {4'b0, frame.width} &&
						({1'b0, fy} + {1'b0, fh}) <= {4'b0, frame.height};
					pix_bytes = '0;
					if (ok) begin
						pix_bytes = {48'b0, fw} * {48'b0, fh} * 64'd2;
						ok = {38'b0, it.len} == 64'd8 + pix_bytes &&
							frame.rects < regs.max_rects &&
							{32'b0, frame.bytes} + pix_bytes <= 64'hFFFF_FFFF;
					end
					if (!ok) begin
						drop_frame(R_RECT);
					end else begin
						frame.rects = frame.rects + 16'd1;
						frame.bytes = frame.bytes + pix_bytes[31:0];
						r = '0;
						r.event_res = EV_RECT;
						r.size_w = fw[12:0];
						r.size_h = fh[12:0];
						r.pos_x = fx[11:0];
						r.pos_y = fy[11:0];
						r.byte_total = pix_bytes[31:0];
						events_due.push_back(r);
					end
				end
			end
			OP_END: begin
				if (frame.mode == MODE_IN) begin
					if (it.len != 26'd9)
						drop_frame(R_LAYOUT);
					else if ((it.tl[7:0] & regs.abort_mask) != 8'd0)
						drop_frame(R_ABORTED);
					else if ((it.tl[7:0] & ~regs.abort_mask) != 8'd0)
						drop_frame(R_LAYOUT);
					else if (it.lo[15:0] != frame.id)
						drop_frame(R_ID);
					else if (it.lo[31:16] != frame.rects)
						drop_frame(R_RECTS);
					else if (it.hi != frame.bytes)
						drop_frame(R_BYTES);
					else if (frame.partial && !frame.base)
						drop_frame(R_PARTIAL);
					else begin
						r = frame_event(EV_COMMIT);
						r.rect_total = frame.rects;
						r.byte_total = frame.bytes;
						events_due.push_back(r);
						clear_frame();
						frame.base = 1'b1;
					end
				end
			end
			OP_STREAM: begin
				if (frame.mode == MODE_IN)
					drop_frame(R_STREAM);
			end
			OP_RESET: begin
				if (frame.mode == MODE_IN)
					drop_frame(R_RESET);
				clear_frame();
				frame.base = 1'b0;
			end
			default: begin
			end
		endcase
		if (events_due.size() > n0) begin
			r = events_due.pop_back();
			r.last = 1'b1;
			events_due.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = CFG_RESET;
			frame = '0;
			events_due.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {event_res, reason, frame_id, frame_kind, pixel_format, size_w,
					size_h, pos_x, pos_y, rect_total, byte_total, last};
				if (events_due.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: event with none due: %s", $time, show(got));
					mismatches <= mismatches + 1;
				end else begin
					want = events_due.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display("%0t: event mismatch\n  expected %s\n  actual   %s",
								$time, show(want), show(got));
						mismatches <= mismatches + 1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					CFG_MAX_PAYLOAD:  regs.max_payload = cfg_data;
					CFG_MAX_RECTS:    regs.max_rects = cfg_data[15:0];
					CFG_FULL_CODE:    regs.full_code = cfg_data[7:0];
					CFG_PARTIAL_CODE: regs.partial_code = cfg_data[7:0];
					CFG_RGB565_CODE:  regs.rgb565_code = cfg_data[7:0];
					CFG_ABORT_MASK:   regs.abort_mask = cfg_data[7:0];
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall)
				predict_events({opcode, payload_len, head_low, head_high, head_tail});
			outstanding <= events_due.size();
		end
	end

endmodule

>>> test/frame_message_validator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_message_validator_top_tb
// Stimulus and verdict for the frame message validator.
// ----------------------------------------------------------------------------
// A directed run walks every opcode but OP_OTHER and every discard reason,
// then a frame long enough to overflow the byte count. Random frames follow,
// mostly well formed with random content and some corrupted, mixed with
// random noise items, under several register settings including the
// extremes. Both sides idle at random; the receiver holds off once for a long
// stretch and the sender waits six times for every event to drain. Checking
// is done by fmv_event_checker.
// ----------------------------------------------------------------------------
module frame_message_validator_top_tb;
	import fmv_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = '0;
	logic [25:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic [2:0]  opcode = '0;
	logic [25:0] payload_len = '0;
	logic [31:0] head_low = '0;
	logic [31:0] head_high = '0;
	logic [31:0] head_tail = '0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  event_res;
	logic [3:0]  reason;
	logic [15:0] frame_id;
	logic        frame_kind;
	logic [7:0]  pixel_format;
	logic [12:0] size_w;
	logic [12:0] size_h;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	logic [15:0] rect_total;
	logic [31:0] byte_total;
	logic        last;
	int          mismatches;
	int          outstanding;

	cfg_t regs = CFG_RESET;
	int   sent = 0;
	bit   steady = 1'b0;
	bit   hold_go = 1'b0;
	bit   hold_done = 1'b0;
	int   hold_left = 0;

	frame_message_validator_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .payload_len(payload_len),
		.head_low(head_low), .head_high(head_high), .head_tail(head_tail),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_res(event_res), .reason(reason), .frame_id(frame_id),
		.frame_kind(frame_kind), .pixel_format(pixel_format),
		.size_w(size_w), .size_h(size_h), .pos_x(pos_x), .pos_y(pos_y),
		.rect_total(rect_total), .byte_total(byte_total), .last(last)
	);

	fmv_event_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .payload_len(payload_len),
		.head_low(head_low), .head_high(head_high), .head_tail(head_tail),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_res(event_res), .reason(reason), .frame_id(frame_id),
		.frame_kind(frame_kind), .pixel_format(pixel_format),
		.size_w(size_w), .size_h(size_h), .pos_x(pos_x), .pos_y(pos_y),
		.rect_total(rect_total), .byte_total(byte_total), .last(last),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("** frame_message_validator_top: FAILED **");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 300;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !steady && ($urandom_range(99) < 22);
		end
	end

	function automatic item_t begin_msg(logic [15:0] id, logic [7:0] kind, logic [7:0] fmt,
			logic [15:0] w, logic [15:0] h, logic [31:0] hint);
		return {OP_BEGIN, 26'd12, {fmt, kind, id}, {h, w}, hint};
	endfunction

	function automatic item_t rect_msg(logic [15:0] x, logic [15:0] y, logic [15:0] w,
			logic [15:0] h);
		logic [31:0] n;
		n = 32'd8 + 32'd2 * w * h;
		return {OP_RECT, n[25:0], {y, x}, {h, w}, $urandom()};
	endfunction

	function automatic item_t end_msg(logic [15:0] id, logic [15:0] rects, logic [31:0] bytes,
			logic [7:0] flags);
		logic [31:0] t;
		t = $urandom();
		t[7:0] = flags;
		return {OP_END, 26'd9, {rects, id}, bytes, t};
	endfunction

	function automatic item_t other_msg(logic [2:0] op);
		return {op, 26'($urandom()), $urandom(), $urandom(), $urandom()};
	endfunction

	task automatic send_item(input item_t it);
		bit taken;
		while (!steady && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{opcode, payload_len, head_low, head_high, head_tail} <= it;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [25:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		put_reg(CFG_MAX_PAYLOAD, c.max_payload);
		put_reg(CFG_MAX_RECTS, {10'b0, c.max_rects});
		put_reg(CFG_FULL_CODE, {18'b0, c.full_code});
		put_reg(CFG_PARTIAL_CODE, {18'b0, c.partial_code});
		put_reg(CFG_RGB565_CODE, {18'b0, c.rgb565_code});
		put_reg(CFG_ABORT_MASK, {18'b0, c.abort_mask});
		cfg_we <= 1'b0;
		regs = c;
	endtask

	task automatic send_frame();
		logic [15:0] id;
		logic [15:0] fw;
		logic [15:0] fh;
		logic [15:0] rw;
		logic [15:0] rh;
		logic [15:0] nrect;
		logic [31:0] total;
		logic [7:0]  kind;
		item_t       it;
		int          n;
		id = 16'($urandom());
		fw = ($urandom_range(9) == 0) ? 16'($urandom_range(1, 4096)) : 16'($urandom_range(1, 12));
		fh = ($urandom_range(9) == 0) ? 16'($urandom_range(1, 4096)) : 16'($urandom_range(1, 12));
		kind = $urandom_range(1) ? regs.partial_code : regs.full_code;
		it = begin_msg(id, kind, regs.rgb565_code, fw, fh, $urandom());
		if ($urandom_range(19) == 0) begin
			case ($urandom_range(4))
				0: it.len = 26'($urandom_range(0, 40));
				1: it.lo[31:24] = it.lo[31:24] + 8'($urandom_range(1, 255));
				2: it.hi[15:0] = $urandom_range(1) ? 16'd0 : 16'($urandom_range(4097, 65535));
				3: it.hi[31:16] = $urandom_range(1) ? 16'd0 : 16'($urandom_range(4097, 65535));
				default: it.lo[23:16] = 8'($urandom());
			endcase
		end
		send_item(it);
		nrect = '0;
		total = '0;
		n = $urandom_range(0, 5);
		repeat (n) begin
			rw = 16'($urandom_range(1, fw < 6 ? fw : 6));
			rh = 16'($urandom_range(1, fh < 6 ? fh : 6));
			it = rect_msg(16'($urandom_range(0, fw - rw)), 16'($urandom_range(0, fh - rh)),
				rw, rh);
			if ($urandom_range(24) == 0) begin
				case ($urandom_range(3))
					0: it.len = it.len + 26'd2;
					1: it.hi[15:0] = '0;
					2: it.lo[15:0] = fw;
					default: it.len = 26'($urandom());
				endcase
			end else begin
				nrect = nrect + 16'd1;
				total = total + 32'd2 * rw * rh;
			end
			send_item(it);
			if ($urandom_range(14) == 0)
				send_item(other_msg(OP_OTHER));
		end
		it = end_msg(id, nrect, total, 8'h00);
		case ($urandom_range(15))
			0: it.len = 26'($urandom_range(0, 20));
			1: it.tl[7:0] = 8'($urandom_range(1, 255));
			2: it.lo[15:0] = ~id;
			3: it.lo[31:16] = nrect + 16'd1;
			4: it.hi = total ^ (32'd1 << $urandom_range(31));
			5: return;
			6: it = other_msg(OP_STREAM);
			7: it = other_msg(OP_RESET);
			default: begin
			end
		endcase
		send_item(it);
	endtask

	task automatic run_mix(input int goal);
		int stop;
		stop = sent + goal;
		while (sent < stop) begin
			if ($urandom_range(99) < 12)
				send_item(other_msg(3'($urandom_range(7))));
			else
				send_frame();
		end
	endtask

	initial begin
		item_t it;
		cfg_t  c;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk, register values as after reset
		send_item(begin_msg(16'hFFFF, 8'd0, 8'd0, 16'd1, 16'd1, 32'hFFFF_FFFF));
		send_item(rect_msg(16'd0, 16'd0, 16'd1, 16'd1));
		send_item(end_msg(16'hFFFF, 16'd1, 32'd2, 8'h00));
		send_item(begin_msg(16'h0000, 8'd1, 8'd0, 16'd4096, 16'd4096, 32'd0));
		send_item(rect_msg(16'd4095, 16'd4095, 16'd1, 16'd1));
		send_item(begin_msg(16'h0007, 8'd1, 8'd0, 16'd4096, 16'd1, 32'h1234_5678));
		send_item(rect_msg(16'd4000, 16'd0, 16'd97, 16'd1));
		send_item(begin_msg(16'h0003, 8'd1, 8'd0, 16'd2, 16'd2, 32'd0));
		send_item(end_msg(16'h0003, 16'd0, 32'd0, 8'h01));
		it = begin_msg(16'h0004, 8'd0, 8'd0, 16'd2, 16'd2, 32'd0);
		it.len = 26'd13;
		send_item(it);
		send_item(begin_msg(16'h0009, 8'd0, 8'd0, 16'd10, 16'd10, 32'd0));
		send_item(end_msg(16'h0009, 16'd0, 32'd0, 8'h80));
		send_item(begin_msg(16'h0005, 8'd0, 8'd0, 16'd3, 16'd3, 32'd0));
		it = end_msg(16'h0005, 16'd0, 32'd0, 8'h00);
		it.len = 26'd10;
		send_item(it);
		send_item(begin_msg(16'h0005, 8'd0, 8'd0, 16'd3, 16'd3, 32'd0));
		send_item(end_msg(16'h0006, 16'd0, 32'd0, 8'h00));
		send_item(begin_msg(16'h0005, 8'd0, 8'd0, 16'd3, 16'd3, 32'd0));
		send_item(end_msg(16'h0005, 16'd1, 32'd0, 8'h00));
		send_item(begin_msg(16'h0005, 8'd0, 8'd0, 16'd3, 16'd3, 32'd0));
		send_item(end_msg(16'h0005, 16'd0, 32'd4, 8'h00));
		send_item(other_msg(OP_RESET));
		send_item(begin_msg(16'h0001, 8'd1, 8'd0, 16'd4, 16'd4, 32'd0));
		send_item(end_msg(16'h0001, 16'd0, 32'd0, 8'h00));
		send_item(other_msg(OP_STREAM));
		send_item(begin_msg(16'h0002, 8'd0, 8'd0, 16'd1, 16'd1, 32'd0));
		send_item(other_msg(OP_STREAM));
		send_item(begin_msg(16'h0002, 8'd0, 8'd0, 16'd1, 16'd1, 32'd0));
		send_item(other_msg(OP_RESET));
		send_item(rect_msg(16'd0, 16'd0, 16'd1, 16'd1));
		send_item(begin_msg(16'h0008, 8'd0, 8'd1, 16'd1, 16'd1, 32'd0));

		// full-size rects until the byte count would pass 32 bits
		send_item(begin_msg(16'h0BAD, 8'd0, 8'd0, 16'd4096, 16'd4096, 32'd0));
		repeat (128) send_item(rect_msg(16'd0, 16'd0, 16'd4096, 16'd4096));

		steady <= 1'b1;
		run_mix(200);
		steady <= 1'b0;
		run_mix(200);
		drain();

		c = '{max_payload: 26'd12, max_rects: 16'd1, full_code: 8'hFF, partial_code: 8'hFF,
			rgb565_code: 8'hFF, abort_mask: 8'hFF};
		program_regs(c);
		run_mix(350);
		drain();

		c = '{max_payload: 26'd33554440, max_rects: 16'hFFFF, full_code: 8'h5A,
			partial_code: 8'hA5, rgb565_code: 8'h77, abort_mask: 8'h80};
		program_regs(c);
		hold_go <= 1'b1;
		run_mix(350);
		drain();

		c.max_payload = 26'($urandom_range(12, 33554440));
		c.max_rects = 16'($urandom_range(1, 4));
		c.full_code = 8'($urandom_range(255));
		c.partial_code = 8'($urandom_range(255));
		c.rgb565_code = 8'($urandom_range(255));
		c.abort_mask = 8'($urandom_range(1, 255));
		program_regs(c);
		run_mix(150);
		drain();
		run_mix(200);
		drain();

		c = CFG_RESET;
		c.max_rects = 16'd3;
		c.abort_mask = 8'hFF;
		program_regs(c);
		run_mix(300);
		drain();
		repeat (10) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("** frame_message_validator_top: PASSED **");
		else
			$display("** frame_message_validator_top: FAILED **");
		$finish;
	end

endmodule
